@@ rtl/core/shanc_pkg.sv @@
// shanc_pkg: shared types, constants and helper functions for the nonce trial checker
// no dependencies; used by the decimal cells, the round cells and the top level
`default_nettype none
package shanc_pkg;

  // register indexes of the configuration port
  localparam logic [2:0] REG_PREV0 = 3'd0;
  localparam logic [2:0] REG_PREV1 = 3'd1;
  localparam logic [2:0] REG_PREV2 = 3'd2;
  localparam logic [2:0] REG_PREV3 = 3'd3;
  localparam logic [2:0] REG_ZEROS = 3'd4;

  localparam int NONCE_W  = 31;   // width of the nonce field
  localparam int DIGITS   = 10;   // decimal digits of the widest nonce
  localparam logic [6:0] ZEROS_RESET = 7'd6;
  localparam logic [6:0] ZEROS_MAX   = 7'd64;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_A_OFS = 8'h57;  // 'a' minus ten
  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [31:0] RECIP_TEN  = 32'hCCCCCCCD;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0][31:0] INIT_H = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  // decimal conversion beat: remaining value and digits so far, least significant first
  typedef struct packed {
    logic                      vld;
    logic [NONCE_W-1:0]        nonce;
    logic [NONCE_W-1:0]        rest;
    logic                      done;
    logic [3:0]                nd;
    logic [DIGITS-1:0][3:0]    digs;
  } dec_t;

  // hash beat: working state, schedule window and carried words
  typedef struct packed {
    logic                 vld;
    logic [NONCE_W-1:0]   nonce;
    logic [7:0][31:0]     st;    // a at index 0
    logic [15:0][31:0]    w;     // current word at index 0
    logic [15:0][31:0]    aux;   // second block, later the mid-state
  } slot_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
    return (nib < 4'd10) ? (ASCII_ZERO + {4'd0, nib}) : (ASCII_A_OFS + {4'd0, nib});
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/shanc_dec_cell.sv @@
// shanc_dec_cell: one decimal digit per cell, divide by ten through a reciprocal multiply
// depends on shanc_pkg
`default_nettype none
module shanc_dec_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  shanc_pkg::dec_t     dec_i,
  output shanc_pkg::dec_t     dec_o
);

  shanc_pkg::dec_t dec_d, dec_q;
  logic [62:0]     prod;
  logic [27:0]     quo;
  logic [31:0]     rem_full;

  // quotient and remainder of the remaining value
  always_comb begin
    prod     = {32'd0, dec_i.rest} * {31'd0, shanc_pkg::RECIP_TEN};
    quo      = prod[62:35];
    rem_full = {1'b0, dec_i.rest} - ({4'd0, quo} * 32'd10);
    dec_d    = dec_i;
    if (!dec_i.done) begin
      for (int j = 0; j < shanc_pkg::DIGITS; j++) begin
        if (dec_i.nd == 4'(j)) dec_d.digs[j] = rem_full[3:0];
      end
      dec_d.nd   = dec_i.nd + 4'd1;
      dec_d.rest = {3'd0, quo};
      dec_d.done = (quo == 28'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_q.vld <= 1'b0;
    end else if (en_i) begin
      dec_q <= dec_d;
    end
  end

  assign dec_o = dec_q;

endmodule
`default_nettype wire

@@ rtl/core/shanc_round_cell.sv @@
// shanc_round_cell: one SHA-256 round with its message schedule step, registered
// depends on shanc_pkg
`default_nettype none
module shanc_round_cell #(
  parameter int ROUND = 0
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  shanc_pkg::slot_t    slot_i,
  output shanc_pkg::slot_t    slot_o
);

  shanc_pkg::slot_t slot_d, slot_q;
  logic [31:0] a, b, c, d, e, f, g, h;
  logic [31:0] t1, t2, s0, s1;

  always_comb begin
    a = slot_i.st[0]; b = slot_i.st[1]; c = slot_i.st[2]; d = slot_i.st[3];
    e = slot_i.st[4]; f = slot_i.st[5]; g = slot_i.st[6]; h = slot_i.st[7];
    // round function
    t1 = h + (shanc_pkg::rotr(e, 6) ^ shanc_pkg::rotr(e, 11) ^ shanc_pkg::rotr(e, 25))
           + ((e & f) ^ (~e & g)) + shanc_pkg::ROUND_K[ROUND] + slot_i.w[0];
    t2 = (shanc_pkg::rotr(a, 2) ^ shanc_pkg::rotr(a, 13) ^ shanc_pkg::rotr(a, 22))
       + ((a & b) ^ (a & c) ^ (b & c));
    // schedule window slides by one word
    s0 = shanc_pkg::rotr(slot_i.w[1], 7) ^ shanc_pkg::rotr(slot_i.w[1], 18)
       ^ (slot_i.w[1] >> 3);
    s1 = shanc_pkg::rotr(slot_i.w[14], 17) ^ shanc_pkg::rotr(slot_i.w[14], 19)
       ^ (slot_i.w[14] >> 10);
    slot_d       = slot_i;
    slot_d.st[0] = t1 + t2;
    slot_d.st[1] = a;
    slot_d.st[2] = b;
    slot_d.st[3] = c;
    slot_d.st[4] = d + t1;
    slot_d.st[5] = e;
    slot_d.st[6] = f;
    slot_d.st[7] = g;
    for (int j = 0; j < 15; j++) slot_d.w[j] = slot_i.w[j+1];
    slot_d.w[15] = slot_i.w[0] + s0 + slot_i.w[9] + s1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q.vld <= 1'b0;
    end else if (en_i) begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;

endmodule
`default_nettype wire

@@ rtl/core/sha256_nonce_trial_check.sv @@
// sha256_nonce_trial_check: fully pipelined proof-of-work trial, one nonce a cycle unless a result waits
// pipeline: 10 decimal digit cells, 128 round cells, one result register
// throughput one beat a cycle; the whole chain holds while a result waits untaken
// reset clears every valid flag, the hash words to 0 and the digit count to 6
// depends on shanc_pkg, shanc_dec_cell, shanc_round_cell
`default_nettype none
module sha256_nonce_trial_check #(
  parameter int NONCE_BITS = 31
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [2:0]   cfg_index_i,
  input  wire logic [63:0]  cfg_data_i,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic [30:0]  trial_nonce_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic              found_o,
  output logic [30:0]       nonce_echo_o,
  output logic [63:0]       digest_word0_o,
  output logic [63:0]       digest_word1_o,
  output logic [63:0]       digest_word2_o,
  output logic [63:0]       digest_word3_o
);

  localparam int EFF_BITS = (NONCE_BITS > shanc_pkg::NONCE_W) ? shanc_pkg::NONCE_W : NONCE_BITS;
  localparam logic [30:0] NONCE_MASK = {31{1'b1}} >> (shanc_pkg::NONCE_W - EFF_BITS);
  localparam int ROUNDS = 128;

  logic [3:0][63:0] prev_q;
  logic [6:0]       req_q;
  logic             en;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      req_q  <= shanc_pkg::ZEROS_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        shanc_pkg::REG_PREV0: prev_q[0] <= cfg_data_i;
        shanc_pkg::REG_PREV1: prev_q[1] <= cfg_data_i;
        shanc_pkg::REG_PREV2: prev_q[2] <= cfg_data_i;
        shanc_pkg::REG_PREV3: prev_q[3] <= cfg_data_i;
        shanc_pkg::REG_ZEROS: req_q     <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // global advance: the chain moves unless a result is held
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // decimal digit chain
  shanc_pkg::dec_t dec_c [shanc_pkg::DIGITS+1];
  always_comb begin
    dec_c[0]       = '0;
    dec_c[0].vld   = in_valid_i && en;
    dec_c[0].nonce = trial_nonce_i & NONCE_MASK;
    dec_c[0].rest  = trial_nonce_i & NONCE_MASK;
  end

  for (genvar k = 0; k < shanc_pkg::DIGITS; k++) begin : g_dec
    shanc_dec_cell u_dec (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .dec_i  (dec_c[k]),
      .dec_o  (dec_c[k+1])
    );
  end

  // both message blocks built for the first round cell
  shanc_pkg::slot_t slot_c [ROUNDS+1];
  shanc_pkg::dec_t  dl;
  logic [63:0][7:0] blk0, blk1;
  logic [15:0]      len_bits;

  always_comb begin
    dl = dec_c[shanc_pkg::DIGITS];
    for (int i = 0; i < 64; i++) begin
      blk0[i] = shanc_pkg::hex_ascii(prev_q[i/16][(15 - (i % 16)) * 4 +: 4]);
    end
    blk1 = '0;
    for (int k = 0; k <= shanc_pkg::DIGITS; k++) begin
      if (4'(k) < dl.nd) begin
        blk1[k] = shanc_pkg::ASCII_ZERO + {4'd0, dl.digs[dl.nd - 4'(k) - 4'd1]};
      end else if (4'(k) == dl.nd) begin
        blk1[k] = shanc_pkg::PAD_BYTE;
      end
    end
    len_bits = 16'd512 + {9'd0, dl.nd, 3'd0};
    blk1[62] = len_bits[15:8];
    blk1[63] = len_bits[7:0];
    slot_c[0]       = '0;
    slot_c[0].vld   = dl.vld;
    slot_c[0].nonce = dl.nonce;
    slot_c[0].st    = shanc_pkg::INIT_H;
    for (int m = 0; m < 16; m++) begin
      slot_c[0].w[m]   = {blk0[4*m], blk0[4*m+1], blk0[4*m+2], blk0[4*m+3]};
      slot_c[0].aux[m] = {blk1[4*m], blk1[4*m+1], blk1[4*m+2], blk1[4*m+3]};
    end
  end

  // hand-over between blocks: mid-state formed, second block loaded
  shanc_pkg::slot_t mid_s;
  always_comb begin
    mid_s = slot_c[64];
    for (int j = 0; j < 8; j++) begin
      mid_s.st[j]  = shanc_pkg::INIT_H[j] + slot_c[64].st[j];
      mid_s.aux[j] = shanc_pkg::INIT_H[j] + slot_c[64].st[j];
    end
    mid_s.w = slot_c[64].aux;
  end

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    shanc_round_cell #(.ROUND(r % 64)) u_round (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .slot_i ((r == 64) ? mid_s : slot_c[r]),
      .slot_o (slot_c[r+1])
    );
  end

  // final add and leading digit check
  logic [7:0][31:0] dg;
  logic [255:0]     dg_flat;
  logic [6:0]       need;
  logic             ok;
  always_comb begin
    for (int j = 0; j < 8; j++) dg[j] = slot_c[ROUNDS].aux[j] + slot_c[ROUNDS].st[j];
    dg_flat = {dg[0], dg[1], dg[2], dg[3], dg[4], dg[5], dg[6], dg[7]};
    need    = (req_q > shanc_pkg::ZEROS_MAX) ? shanc_pkg::ZEROS_MAX : req_q;
    ok      = 1'b1;
    for (int i = 0; i < 64; i++) begin
      if ((7'(i) < need) && (dg_flat[255 - 4*i -: 4] != 4'd0)) ok = 1'b0;
    end
  end

  // result register
  logic              found_q;
  logic [30:0]       nonce_q;
  logic [3:0][63:0]  dig_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= slot_c[ROUNDS].vld;
      found_q     <= ok;
      nonce_q     <= slot_c[ROUNDS].nonce;
      dig_q       <= {dg_flat[255:192], dg_flat[191:128], dg_flat[127:64], dg_flat[63:0]};
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign nonce_echo_o   = nonce_q;
  assign digest_word0_o = dig_q[3];
  assign digest_word1_o = dig_q[2];
  assign digest_word2_o = dig_q[1];
  assign digest_word3_o = dig_q[0];

`ifndef NO_ASSERTIONS
  // a reported hit always has a zero leading digit when digits are required
  a_found_lead : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o && (req_q != 7'd0) |-> digest_word0_o[63:60] == 4'd0)
    else $error("hit reported with nonzero leading digit");
  // no required digits means every trial is a hit
  a_found_none : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (req_q == 7'd0) |-> found_o)
    else $error("miss reported with no digits required");
  // the chain holds while a result waits
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while result held");
`endif

endmodule
`default_nettype wire

@@ tb/sha256_nonce_trial_check_test.sv @@
// sha256_nonce_trial_check_test: self-checking bench for the nonce trial checker
// computes sha-256 of hex hash plus decimal nonce on the bench side; needs shanc_pkg and the rtl
`timescale 1ns / 100ps
`default_nettype none
module sha256_nonce_trial_check_test;

  typedef struct packed {
    logic         found;
    logic [30:0]  nonce;
    logic [255:0] digest;
  } trial_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic [2:0] cfg_index = shanc_pkg::REG_PREV0;
  logic [63:0] cfg_data = '0;
  logic cfg_ready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [30:0] trial_nonce = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic found;
  logic [30:0] nonce_echo;
  logic [63:0] dg0, dg1, dg2, dg3;

  logic [30:0] nonce_q[$];
  trial_t      expected_q[$];
  int          fails = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_off_cycles = 0;
  logic [255:0] prev_hash = '0;
  logic [6:0]  zero_digits = shanc_pkg::ZEROS_RESET;
  int          directed_nonces[11] = '{0, 1, 9, 10, 99, 100, 999999999, 1000000000,
                                       2147483647, 1431655765, 715827882};

  always #5 clk = ~clk;

  sha256_nonce_trial_check i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .trial_nonce_i(trial_nonce),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .found_o(found), .nonce_echo_o(nonce_echo),
    .digest_word0_o(dg0), .digest_word1_o(dg1),
    .digest_word2_o(dg2), .digest_word3_o(dg3)
  );

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    return (n < 10) ? 8'h30 + 8'(n) : 8'h57 + 8'(n);
  endfunction

  // one sha-256 compression over a 512-bit block, first byte at the top
  function automatic logic [255:0] sha_block(logic [255:0] hin, logic [511:0] blk);
    logic [31:0] w[64];
    logic [31:0] h[8];
    logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
    for (int i = 0; i < 8; i++) h[i] = hin[255 - 32 * i -: 32];
    for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
    for (int i = 16; i < 64; i++) begin
      s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4]; f = h[5]; g = h[6]; hh = h[7];
    for (int i = 0; i < 64; i++) begin
      t1 = hh + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
           + shanc_pkg::ROUND_K[i] + w[i];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      hh = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    return {h[0] + a, h[1] + b, h[2] + c, h[3] + d, h[4] + e, h[5] + f, h[6] + g, h[7] + hh};
  endfunction

  // full proof-of-work trial for one nonce under the current registers
  function automatic trial_t pow_trial(logic [30:0] nonce);
    logic [1023:0] msg;
    logic [7:0] digs[10];
    logic [30:0] v;
    int nd, len, need;
    logic [255:0] st;
    trial_t r;
    msg = '0;
    for (int i = 0; i < 64; i++)
      msg[1023 - 8 * i -: 8] = hex_char(prev_hash[255 - 4 * i -: 4]);
    v = nonce; nd = 0;
    do begin
      digs[nd] = 8'h30 + 8'(v % 10);
      v = v / 10; nd++;
    end while (v != 0);
    len = 64;
    for (int i = nd - 1; i >= 0; i--) begin
      msg[1023 - 8 * len -: 8] = digs[i];
      len++;
    end
    msg[1023 - 8 * len -: 8] = 8'h80;
    msg[63:0] = 64'(len * 8);
    st = sha_block({32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19},
                   msg[1023:512]);
    st = sha_block(st, msg[511:0]);
    need = (zero_digits > 64) ? 64 : int'(zero_digits);
    r.found = 1'b1;
    for (int i = 0; i < need; i++)
      if (st[255 - 4 * i -: 4] != 4'h0) r.found = 1'b0;
    r.nonce = nonce;
    r.digest = st;
    return r;
  endfunction

  // append one nonce to the pending input list
  function automatic void add_nonce(logic [30:0] n);
    nonce_q.insert(nonce_q.size(), n);
  endfunction

  // register write, only while the pipeline is empty
  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      shanc_pkg::REG_PREV0: prev_hash[255:192] = val;
      shanc_pkg::REG_PREV1: prev_hash[191:128] = val;
      shanc_pkg::REG_PREV2: prev_hash[127:64] = val;
      shanc_pkg::REG_PREV3: prev_hash[63:0] = val;
      shanc_pkg::REG_ZEROS: zero_digits = val[6:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    while (nonce_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic logic [30:0] rand_nonce;
    case ($urandom_range(3))
      0: return 31'($urandom_range(999));
      1: return 31'($urandom_range(99999999));
      default: return 31'($urandom);
    endcase
  endfunction

  // input driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ready) begin
        if (nonce_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          trial_nonce <= nonce_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // expected results are formed at input acceptance
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      expected_q.insert(expected_q.size(), pow_trial(trial_nonce));
  end

  // output stall control, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      out_ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    trial_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected, nonce %0d", nonce_echo);
        fails++;
      end else begin
        exp_r = expected_q.pop_front();
        if (found !== exp_r.found) begin
          $error("found: expected %0d actual %0d", exp_r.found, found); fails++;
        end
        if (nonce_echo !== exp_r.nonce) begin
          $error("nonce_echo: expected %0d actual %0d", exp_r.nonce, nonce_echo); fails++;
        end
        if (dg0 !== exp_r.digest[255:192]) begin
          $error("digest_word0: expected %h actual %h", exp_r.digest[255:192], dg0); fails++;
        end
        if (dg1 !== exp_r.digest[191:128]) begin
          $error("digest_word1: expected %h actual %h", exp_r.digest[191:128], dg1); fails++;
        end
        if (dg2 !== exp_r.digest[127:64]) begin
          $error("digest_word2: expected %h actual %h", exp_r.digest[127:64], dg2); fails++;
        end
        if (dg3 !== exp_r.digest[63:0]) begin
          $error("digest_word3: expected %h actual %h", exp_r.digest[63:0], dg3); fails++;
        end
      end
    end
  end

  // run limit
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  // stimulus phases
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: nonce extremes and digit-count boundaries at reset registers
    foreach (directed_nonces[i]) add_nonce(31'(directed_nonces[i]));
    drain();

    // zero digits required, then all-ones hash
    write_reg(shanc_pkg::REG_ZEROS, 64'd0);
    for (int i = 0; i < 4; i++) write_reg(3'(i), '1);
    for (int i = 0; i < 6; i++) add_nonce(rand_nonce());
    drain();

    // more than 64 digits clamps to the whole digest, then exactly 64 for one nonce
    write_reg(shanc_pkg::REG_ZEROS, 64'd127);
    add_nonce(31'd5); add_nonce(31'h7fffffff);
    drain();
    write_reg(shanc_pkg::REG_ZEROS, 64'd64);
    add_nonce(31'd42);
    drain();

    // random phases across idling mixes, registers changed between phases
    for (int ph = 0; ph < 8; ph++) begin
      for (int i = 0; i < 4; i++) write_reg(3'(i), {$urandom, $urandom});
      write_reg(shanc_pkg::REG_ZEROS,
                64'((ph % 3 == 0) ? $urandom_range(2) : $urandom_range(127)));
      send_idle_pct  = (ph % 4 == 1 || ph % 4 == 3) ? 47 : 0;
      recv_stall_pct = (ph % 4 == 2) ? 47 : (ph % 4 == 3 ? 28 : 0);
      if (ph % 4 == 3) send_idle_pct = 28;
      if (ph == 2) hold_off_cycles = 400;
      for (int i = 0; i < 150; i++) add_nonce(rand_nonce());
      drain();
    end

    // a write with all bits of the data port low, then one required digit
    write_reg(shanc_pkg::REG_PREV2, '0);
    write_reg(shanc_pkg::REG_ZEROS, 64'd1);
    for (int i = 0; i < 20; i++) add_nonce(rand_nonce());
    drain();

    if (fails == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
`default_nettype wire
